### rtl/fdr_pkg.sv
// Shared types and fixed-format constants for the Fresnel reflectance pipeline.
package fdr_pkg;

    localparam int FIELD_W   = 16;
    localparam int ETA_FRAC  = 12;
    localparam int WIDE_FRAC = 24;

    typedef struct packed {
        logic advance;
        logic valid;
    } pipe_ctl_t;

endpackage

### rtl/fdr_div.sv
// Pipelined restoring fraction divider, one quotient bit per stage, with side data.
module fdr_div #(
    parameter int NW    = 56,
    parameter int QB    = 30,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  fdr_pkg::pipe_ctl_t          ctl_in,
    input  logic [LANES-1:0][NW-1:0]    num,
    input  logic [LANES-1:0][NW-1:0]    den,
    input  logic [SW-1:0]               side_in,
    output logic                        valid_out,
    output logic [LANES-1:0][QB-1:0]    quot,
    output logic [SW-1:0]               side_out
);

    logic [QB-1:0]                v_reg;
    logic [LANES-1:0][NW:0]       rem_reg  [QB];
    logic [LANES-1:0][NW-1:0]     den_reg  [QB];
    logic [LANES-1:0][QB-1:0]     q_reg    [QB];
    logic [SW-1:0]                side_reg [QB];

    genvar k;
    generate
        for (k = 0; k < QB; k++) begin : g_stage
            logic                     v_p;
            logic [LANES-1:0][NW:0]   rem_p;
            logic [LANES-1:0][NW-1:0] den_p;
            logic [LANES-1:0][QB-1:0] q_p;
            logic [SW-1:0]            side_p;
            logic [LANES-1:0][NW:0]   rem_next;
            logic [LANES-1:0][QB-1:0] q_next;

            if (k == 0) begin : g_first
                always_comb begin
                    v_p    = ctl_in.valid;
                    den_p  = den;
                    side_p = side_in;
                    for (int l = 0; l < LANES; l++) begin
                        rem_p[l] = {1'b0, num[l]};
                        q_p[l]   = '0;
                    end
                end
            end else begin : g_rest
                always_comb begin
                    v_p    = v_reg[k-1];
                    rem_p  = rem_reg[k-1];
                    den_p  = den_reg[k-1];
                    q_p    = q_reg[k-1];
                    side_p = side_reg[k-1];
                end
            end

            always_comb begin
                logic [NW:0] r2;
                logic        ge;
                for (int l = 0; l < LANES; l++) begin
                    r2 = {rem_p[l][NW-1:0], 1'b0};
                    ge = (r2 >= {1'b0, den_p[l]});
                    rem_next[l] = ge ? (r2 - {1'b0, den_p[l]}) : r2;
                    q_next[l]   = {q_p[l][QB-2:0], ge};
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[k] <= 1'b0;
                end else if (ctl_in.advance) begin
                    v_reg[k] <= v_p;
                end
            end

            always_ff @(posedge aclk) begin
                if (ctl_in.advance) begin
                    rem_reg[k]  <= rem_next;
                    den_reg[k]  <= den_p;
                    q_reg[k]    <= q_next;
                    side_reg[k] <= side_p;
                end
            end
        end
    endgenerate

    assign valid_out = v_reg[QB-1];
    assign quot      = q_reg[QB-1];
    assign side_out  = side_reg[QB-1];

endmodule

### rtl/fdr_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage, with side data.
module fdr_sqrt #(
    parameter int RB = 15,
    parameter int SW = 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  fdr_pkg::pipe_ctl_t ctl_in,
    input  logic [2*RB-1:0]    radicand,
    input  logic [SW-1:0]      side_in,
    output logic               valid_out,
    output logic [RB-1:0]      root,
    output logic [SW-1:0]      side_out
);

    localparam int RW = RB + 3;

    logic [RB-1:0]   v_reg;
    logic [2*RB-1:0] rad_reg  [RB];
    logic [RW-1:0]   rem_reg  [RB];
    logic [RB-1:0]   root_reg [RB];
    logic [SW-1:0]   side_reg [RB];

    genvar k;
    generate
        for (k = 0; k < RB; k++) begin : g_stage
            logic            v_p;
            logic [2*RB-1:0] rad_p;
            logic [RW-1:0]   rem_p;
            logic [RB-1:0]   root_p;
            logic [SW-1:0]   side_p;
            logic [RW-1:0]   rs;
            logic [RW-1:0]   trial;
            logic            ge;

            if (k == 0) begin : g_first
                always_comb begin
                    v_p    = ctl_in.valid;
                    rad_p  = radicand;
                    rem_p  = '0;
                    root_p = '0;
                    side_p = side_in;
                end
            end else begin : g_rest
                always_comb begin
                    v_p    = v_reg[k-1];
                    rad_p  = rad_reg[k-1];
                    rem_p  = rem_reg[k-1];
                    root_p = root_reg[k-1];
                    side_p = side_reg[k-1];
                end
            end

            always_comb begin
                rs    = {rem_p[RW-3:0], rad_p[2*RB-1-2*k -: 2]};
                trial = {1'b0, root_p, 2'b01};
                ge    = (rs >= trial);
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[k] <= 1'b0;
                end else if (ctl_in.advance) begin
                    v_reg[k] <= v_p;
                end
            end

            always_ff @(posedge aclk) begin
                if (ctl_in.advance) begin
                    rad_reg[k]  <= rad_p;
                    rem_reg[k]  <= ge ? (rs - trial) : rs;
                    root_reg[k] <= {root_p[RB-2:0], ge};
                    side_reg[k] <= side_p;
                end
            end
        end
    endgenerate

    assign valid_out = v_reg[RB-1];
    assign root      = root_reg[RB-1];
    assign side_out  = side_reg[RB-1];

endmodule

### rtl/fresnel_dielectric_reflectance_top.sv
// Unpolarized Fresnel reflectance pipeline: top level with handshake and arithmetic stages.
//
// Takes |cos theta_i| (FRAC_BITS fraction bits) and eta (Q4.12) and returns the
// unpolarized reflectance, the transmitted cosine and a total internal reflection
// flag. One item enters per cycle while the output is not stalled; each item passes
// 4*FRAC_BITS+11 register stages: the 2*FRAC_BITS-stage cos_t^2 divider, the
// FRAC_BITS-stage square root and the FRAC_BITS+4-stage two-lane amplitude divider,
// each retiring one bit per stage, plus seven further register stages. A stalled
// output freezes the whole pipeline; the input register still takes one item while
// it is empty.
module fresnel_dielectric_reflectance_top #(
    parameter int FRAC_BITS = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_cos_incident,
    input  logic [15:0] s_rel_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_reflectance,
    output logic [15:0] m_cos_transmitted,
    output logic        m_total_internal_reflection
);

    localparam int F     = FRAC_BITS;
    localparam int FW    = fdr_pkg::FIELD_W;
    localparam int EF    = fdr_pkg::ETA_FRAC;
    localparam int WF    = fdr_pkg::WIDE_FRAC;
    localparam int SINW  = 2 * WF + 1;
    localparam int E2W   = 2 * (FW + WF - EF);
    localparam int AW    = (F + 17 > 33) ? F + 17 : 33;
    localparam int PW    = F + 5;
    localparam int SQW   = 2 * PW;
    localparam int SUMW  = 2 * F + 12;
    localparam int S1W   = 2 * FW + FW + FW + 1;
    localparam int S2W   = F + 5;

    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    fdr_pkg::pipe_ctl_t ctl1, ctl2, ctl3;
    logic adv;

    logic        v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic [FW-1:0] c0_reg, eta0_reg;
    logic [FW-1:0] c1_reg, eta1_reg;
    logic [2*FW-1:0] cc1_reg, ee1_reg, ec1_reg;
    logic [E2W-1:0] num2_reg, den2_reg;
    logic [S1W-1:0] side2_reg;

    logic            d1_valid, sq_valid, d2_valid;
    logic [2*F-1:0]  d1_quot;
    logic [S1W-1:0]  d1_side, sq_side;
    logic [F-1:0]    sq_root;

    logic [F:0]      cos3_reg;
    logic [2*FW-1:0] ec3_reg;
    logic [FW-1:0]   c3_reg;
    logic [FW+F-1:0] et3_reg;
    logic            tir3_reg;

    logic [1:0][AW-1:0] num4_reg, den4_reg;
    logic [S2W-1:0]     side4_reg;
    logic [1:0][F+3:0]  d2_quot;
    logic [S2W-1:0]     d2_side;

    logic [SQW-1:0] sq1_reg, sq2_reg;
    logic [F:0]     cos5_reg;
    logic           tir5_reg, zf5_reg;

    logic [F:0]     refl6_reg;
    logic [F:0]     cos6_reg;
    logic           tir6_reg;

    assign adv     = !v6_reg || m_ready;
    assign s_ready = adv || !v0_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (s_ready) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            c0_reg   <= (32'(s_cos_incident) > 32'(ONE)) ? FW'(ONE) : s_cos_incident;
            eta0_reg <= s_rel_index;
        end
    end

    // squares and cross product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cc1_reg  <= c0_reg * c0_reg;
            ee1_reg  <= eta0_reg * eta0_reg;
            ec1_reg  <= eta0_reg * c0_reg;
            c1_reg   <= c0_reg;
            eta1_reg <= eta0_reg;
        end
    end

    // Snell term and TIR test
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic [SINW-1:0] sin_i2;
        logic [E2W-1:0]  e2;
        logic            tir;
        if (adv) begin
            sin_i2 = (SINW'(1) << (2 * WF)) - (SINW'(cc1_reg) << (2 * WF - 2 * F));
            e2     = E2W'(ee1_reg) << (2 * (WF - EF));
            tir    = (eta1_reg == '0) || ((E2W + 1)'(sin_i2) >= (E2W + 1)'(e2));
            num2_reg  <= tir ? '0 : (e2 - E2W'(sin_i2));
            den2_reg  <= tir ? E2W'(1) : e2;
            side2_reg <= {ec1_reg, c1_reg, eta1_reg, tir};
        end
    end

    assign ctl1 = '{advance: adv, valid: v2_reg};

    fdr_div #(.NW(E2W), .QB(2 * F), .LANES(1), .SW(S1W)) u_div_cos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    (ctl1),
        .num       (num2_reg),
        .den       (den2_reg),
        .side_in   (side2_reg),
        .valid_out (d1_valid),
        .quot      (d1_quot),
        .side_out  (d1_side)
    );

    assign ctl2 = '{advance: adv, valid: d1_valid};

    fdr_sqrt #(.RB(F), .SW(S1W)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    (ctl2),
        .radicand  (d1_quot),
        .side_in   (d1_side),
        .valid_out (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // transmitted cosine and eta * cos_t
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        logic [F:0] cos_t;
        if (adv) begin
            if (sq_side[0]) begin
                cos_t = '0;
            end else if (32'(sq_side[2*FW:FW+1]) == 32'(ONE)) begin
                cos_t = ONE;
            end else begin
                cos_t = {1'b0, sq_root};
            end
            cos3_reg <= cos_t;
            et3_reg  <= sq_side[FW:1] * cos_t;
            ec3_reg  <= sq_side[S1W-1 -: 2*FW];
            c3_reg   <= sq_side[2*FW:FW+1];
            tir3_reg <= sq_side[0];
        end
    end

    // amplitude ratio numerators and denominators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic [AW-1:0] ecw, t12, c12, etw, b1, b2, a1, a2;
        logic          zf, eq1, eq2;
        if (adv) begin
            ecw = AW'(ec3_reg);
            t12 = AW'(cos3_reg) << EF;
            c12 = AW'(c3_reg) << EF;
            etw = AW'(et3_reg);
            b1  = ecw + t12;
            b2  = c12 + etw;
            a1  = (ecw >= t12) ? ecw - t12 : t12 - ecw;
            a2  = (c12 >= etw) ? c12 - etw : etw - c12;
            zf  = (b1 == '0) || (b2 == '0);
            eq1 = (a1 == b1);
            eq2 = (a2 == b2);
            num4_reg[0] <= eq1 ? '0 : a1;
            num4_reg[1] <= eq2 ? '0 : a2;
            den4_reg[0] <= b1;
            den4_reg[1] <= b2;
            side4_reg   <= {cos3_reg, tir3_reg, zf, eq1, eq2};
        end
    end

    assign ctl3 = '{advance: adv, valid: v4_reg};

    fdr_div #(.NW(AW), .QB(F + 4), .LANES(2), .SW(S2W)) u_div_amp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    (ctl3),
        .num       (num4_reg),
        .den       (den4_reg),
        .side_in   (side4_reg),
        .valid_out (d2_valid),
        .quot      (d2_quot),
        .side_out  (d2_side)
    );

    // square the ratios
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        logic [PW-1:0] p1, p2;
        if (adv) begin
            p1 = d2_side[1] ? (PW'(1) << (F + 4)) : PW'(d2_quot[0]);
            p2 = d2_side[0] ? (PW'(1) << (F + 4)) : PW'(d2_quot[1]);
            sq1_reg  <= p1 * p1;
            sq2_reg  <= p2 * p2;
            cos5_reg <= d2_side[S2W-1 -: F+1];
            tir5_reg <= d2_side[3];
            zf5_reg  <= d2_side[2];
        end
    end

    // mean, round and saturate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (adv) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic [SUMW-1:0] sum;
        logic [F+2:0]    r;
        if (adv) begin
            sum = SUMW'(sq1_reg) + SUMW'(sq2_reg) + (SUMW'(1) << (F + 8));
            r   = sum[SUMW-1:F+9];
            if (tir5_reg || zf5_reg || (r > (F + 3)'(ONE))) begin
                refl6_reg <= ONE;
            end else begin
                refl6_reg <= r[F:0];
            end
            cos6_reg <= cos5_reg;
            tir6_reg <= tir5_reg;
        end
    end

    assign m_valid                     = v6_reg;
    assign m_reflectance               = FW'(refl6_reg);
    assign m_cos_transmitted           = FW'(cos6_reg);
    assign m_total_internal_reflection = tir6_reg;

endmodule
